// ===== hdl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; every other file in hdl/ uses this package.
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int LEN_BITS    = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KIND_MSG_BYTE  = 3'd0;
  localparam logic [2:0] KIND_MSG_END   = 3'd1;
  localparam logic [2:0] KIND_MSG_ABORT = 3'd2;
  localparam logic [2:0] KIND_PONG_BYTE = 3'd3;
  localparam logic [2:0] KIND_CLOSE     = 3'd4;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [7:0] PONG_HDR_BYTE = 8'h8A;
  localparam logic [7:0] PONG_LEN_MASK = 8'h80;
  localparam logic [6:0] LEN7_EXT16    = 7'd126;
  localparam logic [6:0] LEN7_EXT64    = 7'd127;
  localparam logic [LEN_BITS-1:0] PING_MAX_LEN = LEN_BITS'(125);

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  localparam logic [31:0] PONG_KEY_RESET = 32'h12345678;

  localparam logic [2:0] PONG_STEP_HDR  = 3'd0;
  localparam logic [2:0] PONG_STEP_LEN  = 3'd1;
  localparam logic [2:0] PONG_STEP_KEY  = 3'd2;
  localparam logic [2:0] PONG_STEP_LAST = 3'd5;

  // One queued command: either a single result word or a pong header burst.
  typedef struct packed {
    logic       pong;
    logic [2:0] kind;
    logic [7:0] data;
    logic       mend;
    logic       pend;
  } cmd_t;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] kb;
    case (idx)
      2'd0:    kb = key[31:24];
      2'd1:    kb = key[23:16];
      2'd2:    kb = key[15:8];
      default: kb = key[7:0];
    endcase
    return kb;
  endfunction

endpackage

// ===== hdl/wsd_front.sv =====
// Front end: accepts received bytes, tracks frame headers and classifies bytes.
// Pushes one command per result-bearing byte into the queue. Uses wsd_pkg.
`timescale 1ns / 1ps

module wsd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic [31:0]        pong_key,
  input  logic               q_full,
  output logic               q_push,
  output wsd_pkg::cmd_t      q_cmd
);

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD, PH_CLOSED
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic                          final_r, final_nxt;
  logic [3:0]                    opcode_r, opcode_nxt;
  logic                          masked_r, masked_nxt;
  logic [wsd_pkg::LEN_BITS-1:0]  rem_r, rem_nxt;
  logic [3:0]                    hcnt_r, hcnt_nxt;
  logic                          msg_open_r, msg_open_nxt;
  logic                          pong_act_r, pong_act_nxt;
  logic [1:0]                    pong_idx_r, pong_idx_nxt;

  logic                          acc;
  logic                          push_c;
  wsd_pkg::cmd_t                 cmd_c;
  logic                          len_done;
  logic                          body;
  logic [3:0]                    hcnt_dec;
  logic [wsd_pkg::LEN_BITS-1:0]  rem_dec;
  logic [wsd_pkg::LEN_BITS-1:0]  ext_val;
  logic                          pay_last;
  logic                          mend;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc && push_c;
  assign q_cmd    = cmd_c;

  assign hcnt_dec = hcnt_r - 4'd1;
  assign rem_dec  = rem_r - wsd_pkg::LEN_BITS'(1);
  assign pay_last = (rem_dec == '0);
  assign ext_val  = (rem_r[wsd_pkg::LEN_BITS-1 -: 8] != 8'd0) ? '1 :
                    {rem_r[wsd_pkg::LEN_BITS-9:0], in_rx_byte};

  always_comb begin
    phase_nxt    = phase_r;
    final_nxt    = final_r;
    opcode_nxt   = opcode_r;
    masked_nxt   = masked_r;
    rem_nxt      = rem_r;
    hcnt_nxt     = hcnt_r;
    msg_open_nxt = msg_open_r;
    pong_act_nxt = pong_act_r;
    pong_idx_nxt = pong_idx_r;
    push_c       = 1'b0;
    cmd_c        = '0;
    len_done     = 1'b0;
    body         = 1'b0;
    mend         = 1'b0;

    case (phase_r)
      PH_CLOSED: begin
      end
      PH_HDR1: begin
        masked_nxt = in_rx_byte[7];
        rem_nxt    = '0;
        if (in_rx_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
          hcnt_nxt  = wsd_pkg::EXT16_BYTES;
          phase_nxt = PH_EXTLEN;
        end else if (in_rx_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
          hcnt_nxt  = wsd_pkg::EXT64_BYTES;
          phase_nxt = PH_EXTLEN;
        end else begin
          rem_nxt  = wsd_pkg::LEN_BITS'(in_rx_byte[6:0]);
          len_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        rem_nxt  = ext_val;
        hcnt_nxt = hcnt_dec;
        len_done = (hcnt_dec == 4'd0);
      end
      PH_MASK: begin
        hcnt_nxt = hcnt_dec;
        body     = (hcnt_dec == 4'd0);
      end
      PH_PAYLOAD: begin
        rem_nxt = rem_dec;
        if (opcode_r == wsd_pkg::OP_CONT || opcode_r == wsd_pkg::OP_TEXT) begin
          mend         = pay_last && final_r;
          push_c       = 1'b1;
          cmd_c.kind   = wsd_pkg::KIND_MSG_BYTE;
          cmd_c.data   = in_rx_byte;
          cmd_c.mend   = mend;
          msg_open_nxt = !mend;
        end else if (opcode_r == wsd_pkg::OP_PING && pong_act_r) begin
          push_c       = 1'b1;
          cmd_c.kind   = wsd_pkg::KIND_PONG_BYTE;
          cmd_c.data   = in_rx_byte ^ wsd_pkg::key_byte(pong_key, pong_idx_r);
          cmd_c.pend   = pay_last;
          pong_idx_nxt = pong_idx_r + 2'd1;
          if (pay_last) begin
            pong_act_nxt = 1'b0;
          end
        end
        if (pay_last) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        final_nxt  = in_rx_byte[7];
        opcode_nxt = in_rx_byte[3:0];
        phase_nxt  = PH_HDR1;
      end
    endcase

    if (len_done) begin
      if (masked_nxt) begin
        hcnt_nxt  = wsd_pkg::MASK_BYTES;
        phase_nxt = PH_MASK;
      end else begin
        body = 1'b1;
      end
    end

    if (body) begin
      if (opcode_r == wsd_pkg::OP_CONT || opcode_r == wsd_pkg::OP_TEXT) begin
        if (opcode_r == wsd_pkg::OP_TEXT && msg_open_r) begin
          push_c       = 1'b1;
          cmd_c.kind   = wsd_pkg::KIND_MSG_ABORT;
          msg_open_nxt = 1'b0;
        end else if (rem_nxt == '0 && final_r && msg_open_r) begin
          push_c       = 1'b1;
          cmd_c.kind   = wsd_pkg::KIND_MSG_END;
          msg_open_nxt = 1'b0;
        end
        phase_nxt = (rem_nxt == '0) ? PH_HDR0 : PH_PAYLOAD;
      end else if (opcode_r == wsd_pkg::OP_CLOSE) begin
        push_c     = 1'b1;
        cmd_c.kind = wsd_pkg::KIND_CLOSE;
        phase_nxt  = PH_CLOSED;
      end else if (opcode_r == wsd_pkg::OP_PING && rem_nxt <= wsd_pkg::PING_MAX_LEN) begin
        push_c       = 1'b1;
        cmd_c.pong   = 1'b1;
        cmd_c.kind   = wsd_pkg::KIND_PONG_BYTE;
        cmd_c.data   = wsd_pkg::PONG_LEN_MASK | {1'b0, rem_nxt[6:0]};
        cmd_c.pend   = (rem_nxt == '0);
        pong_idx_nxt = 2'd0;
        pong_act_nxt = (rem_nxt != '0);
        phase_nxt    = (rem_nxt == '0) ? PH_HDR0 : PH_PAYLOAD;
      end else begin
        phase_nxt = (rem_nxt == '0) ? PH_HDR0 : PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      final_r    <= 1'b0;
      opcode_r   <= 4'd0;
      masked_r   <= 1'b0;
      rem_r      <= '0;
      hcnt_r     <= 4'd0;
      msg_open_r <= 1'b0;
      pong_act_r <= 1'b0;
      pong_idx_r <= 2'd0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      final_r    <= final_nxt;
      opcode_r   <= opcode_nxt;
      masked_r   <= masked_nxt;
      rem_r      <= rem_nxt;
      hcnt_r     <= hcnt_nxt;
      msg_open_r <= msg_open_nxt;
      pong_act_r <= pong_act_nxt;
      pong_idx_r <= pong_idx_nxt;
    end
  end

endmodule

// ===== hdl/wsd_queue.sv =====
// Command queue between the header parser and the result sequencer.
// Small register file with head read in place. Uses wsd_pkg.
`timescale 1ns / 1ps

module wsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wsd_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output wsd_pkg::cmd_t  head,
  output logic           full,
  output logic           empty
);

  wsd_pkg::cmd_t                   mem_r [wsd_pkg::QUEUE_DEPTH];
  logic [wsd_pkg::QPTR_BITS-1:0]   wr_ptr_r;
  logic [wsd_pkg::QPTR_BITS-1:0]   rd_ptr_r;
  logic [wsd_pkg::QCNT_BITS-1:0]   cnt_r;

  assign full  = (cnt_r == wsd_pkg::QCNT_BITS'(wsd_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= wsd_pkg::QCNT_BITS'(wsd_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== hdl/wsd_back.sv =====
// Back end: expands queued commands into result words and holds the output register.
// A pong command becomes a six-word burst. Uses wsd_pkg.
`timescale 1ns / 1ps

module wsd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  wsd_pkg::cmd_t  q_head,
  output logic           q_pop,
  input  logic [31:0]    pong_key,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_kind,
  output logic [7:0]     out_data,
  output logic           out_message_end,
  output logic           out_pong_frame_end,
  output logic           out_run_last
);

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r;
  logic [2:0] kind_r;
  logic [7:0] data_r;
  logic       mend_r;
  logic       pend_r;
  logic       last_r;

  logic       load;
  logic       step_last;
  logic [2:0] key_step;
  logic [7:0] data_c;
  logic       pend_c;
  logic       last_c;

  assign load      = !q_empty && (!out_valid_r || out_ready);
  assign step_last = (step_r == wsd_pkg::PONG_STEP_LAST);
  assign key_step  = step_r - wsd_pkg::PONG_STEP_KEY;
  assign q_pop     = load && (!q_head.pong || step_last);

  always_comb begin
    data_c   = q_head.data;
    pend_c   = q_head.pend;
    last_c   = 1'b1;
    step_nxt = step_r;
    if (q_head.pong) begin
      case (step_r)
        wsd_pkg::PONG_STEP_HDR: data_c = wsd_pkg::PONG_HDR_BYTE;
        wsd_pkg::PONG_STEP_LEN: data_c = q_head.data;
        default:                data_c = wsd_pkg::key_byte(pong_key, key_step[1:0]);
      endcase
      pend_c = q_head.pend && step_last;
      last_c = step_last;
      if (load) begin
        step_nxt = step_last ? wsd_pkg::PONG_STEP_HDR : step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= wsd_pkg::PONG_STEP_HDR;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= q_head.kind;
      data_r <= data_c;
      mend_r <= q_head.mend;
      pend_r <= pend_c;
      last_r <= last_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_data           = data_r;
  assign out_message_end    = mend_r;
  assign out_pong_frame_end = pend_r;
  assign out_run_last       = last_r;

`ifndef NO_ASSERTIONS
  a_burst_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != wsd_pkg::PONG_STEP_HDR) |-> (!q_empty && q_head.pong))
    else $error("pong burst without a pong command at the head");
  a_pend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pend_r) |-> (last_r && kind_r == wsd_pkg::KIND_PONG_BYTE))
    else $error("pong frame end not on a last pong word");
  a_mend_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mend_r) |-> (kind_r == wsd_pkg::KIND_MSG_BYTE && last_r))
    else $error("message end on a word that is not a message byte");
`endif

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// WebSocket frame deframer, receive side: takes one received byte per cycle and
// streams message bytes, message end and abort marks, pong frame bytes and a close
// mark. The header parser accepts a byte every cycle while its four-entry command
// queue has room; the result sequencer drains one word per cycle while out_ready
// is high, so a pong header command costs six output words (0x8A, length, four
// mask bytes) and in_ready falls when the queue is full. Results load from the
// queue head into the output register. Only the last header or mask byte can give
// a result; bytes after a close frame give none. The pong mask key comes from
// cfg_pong_mask_key (reset 0x12345678); the user must write it only while idle;
// this is not enforced. Depends on wsd_pkg, wsd_front, wsd_queue and wsd_back.
`timescale 1ns / 1ps

module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data,
  output logic        out_message_end,
  output logic        out_pong_frame_end,
  output logic        out_run_last,
  input  logic        cfg_we,
  input  logic [31:0] cfg_pong_mask_key
);

  logic [31:0]   key_r;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  wsd_pkg::cmd_t q_cmd;
  wsd_pkg::cmd_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= wsd_pkg::PONG_KEY_RESET;
    end else if (cfg_we) begin
      key_r <= cfg_pong_mask_key;
    end
  end

  wsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .pong_key   (key_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  wsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  wsd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .pong_key           (key_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_data           (out_data),
    .out_message_end    (out_message_end),
    .out_pong_frame_end (out_pong_frame_end),
    .out_run_last       (out_run_last)
  );

endmodule
